// ----- hw/rtl/msdg_pkg.sv -----
// ----------------------------------------------------------------------------
// msdg_pkg
// Shared types and constants for the multi-axis step/direction generator.
// ----------------------------------------------------------------------------
package msdg_pkg;

    localparam int MAX_AXES           = 4;
    localparam int VEL_WIDTH          = 32;
    localparam int PULSE_WIDTH_BITS   = 8;
    localparam int PULSE_COUNT_BITS   = PULSE_WIDTH_BITS + 1;
    localparam int AXIS_COUNT_DEFAULT = 4;
    localparam int STEP_BIT_DEFAULT   = 22;

    localparam logic [PULSE_WIDTH_BITS-1:0] PULSE_WIDTH_RESET = 8'd1;

    typedef logic [VEL_WIDTH-1:0]        vel_t;
    typedef logic [PULSE_WIDTH_BITS-1:0] pulse_width_t;
    typedef logic [PULSE_COUNT_BITS-1:0] pulse_count_t;

    // One tick request.
    typedef struct packed {
        logic        clear;
        logic signed [VEL_WIDTH-1:0] velocity_0;
        logic signed [VEL_WIDTH-1:0] velocity_1;
        logic signed [VEL_WIDTH-1:0] velocity_2;
        logic signed [VEL_WIDTH-1:0] velocity_3;
    } tick_t;

    // One result.
    typedef struct packed {
        logic [MAX_AXES-1:0] step_levels;
        logic [MAX_AXES-1:0] dir_levels;
        logic signed [VEL_WIDTH-1:0] position_0;
        logic signed [VEL_WIDTH-1:0] position_1;
        logic signed [VEL_WIDTH-1:0] position_2;
        logic signed [VEL_WIDTH-1:0] position_3;
    } result_t;

    // Control from the top level to each axis.
    typedef struct packed {
        logic en;
        logic clr;
    } axis_ctrl_t;

    // Per-axis state after the tick.
    typedef struct packed {
        logic step;
        logic dir;
        vel_t position;
    } axis_out_t;

endpackage

// ----- hw/rtl/multi_axis_step_dir_generator.sv -----
// ----------------------------------------------------------------------------
// multi_axis_step_dir_generator
// Phase-accumulator step/direction generator for up to four axes.
// ----------------------------------------------------------------------------
// Takes one tick request per clock and returns one result per request. Each
// request passes the input register, then the result register. Each axis
// does one 32-bit add plus a few small compares per tick, and that axis path
// sets the clock rate. While the result register holds a result that is not
// taken, a loaded input register holds too and tick_ready drops; otherwise a
// request is taken every cycle. The user must write pulse_width through cfg_*
// only while the block is idle; the block itself does not enforce it.
module multi_axis_step_dir_generator
    import msdg_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEFAULT,
    parameter int STEP_BIT   = STEP_BIT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tick_valid,
    output logic         tick_ready,
    input  tick_t        tick_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_t      result_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  pulse_width_t cfg_data
);

    pulse_width_t pulse_width_reg;
    tick_t        tick_reg;
    logic         tick_valid_reg;
    result_t      result_reg, result_next;
    logic         result_valid_reg;
    logic         advance;

    vel_t                velocity [MAX_AXES];
    axis_out_t           axis_out [MAX_AXES];
    logic [MAX_AXES-1:0] step_bits;
    logic [MAX_AXES-1:0] dir_bits;
    axis_ctrl_t          axis_ctrl;

    assign advance    = tick_valid_reg && (!result_valid_reg || result_ready);
    assign tick_ready = !tick_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign axis_ctrl.en  = advance;
    assign axis_ctrl.clr = tick_reg.clear;

    assign velocity[0] = tick_reg.velocity_0;
    assign velocity[1] = tick_reg.velocity_1;
    assign velocity[2] = tick_reg.velocity_2;
    assign velocity[3] = tick_reg.velocity_3;

    for (genvar g = 0; g < MAX_AXES; g++)
    begin : g_axis
        if (g < AXIS_COUNT)
        begin : g_on
            msdg_axis #(
                .STEP_BIT (STEP_BIT)
            ) u_axis (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (axis_ctrl),
                .pulse_width (pulse_width_reg),
                .velocity    (velocity[g]),
                .next_out    (axis_out[g])
            );
        end
        else
        begin : g_off
            assign axis_out[g] = '0;
        end
        assign step_bits[g] = axis_out[g].step;
        assign dir_bits[g]  = axis_out[g].dir;
    end

    always_comb
    begin
        result_next.step_levels = step_bits;
        result_next.dir_levels  = dir_bits;
        result_next.position_0  = axis_out[0].position;
        result_next.position_1  = axis_out[1].position;
        result_next.position_2  = axis_out[2].position;
        result_next.position_3  = axis_out[3].position;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg  <= PULSE_WIDTH_RESET;
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pulse_width_reg <= cfg_data;
            end
            if (tick_ready)
            begin
                tick_valid_reg <= tick_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            tick_reg <= tick_data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // A clear request yields an all-zero result.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tick_reg.clear) |=> (result_reg == '0))
        else $error("clear request did not give a zero result");

    // Unused axes stay quiet.
    a_unused_axes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (((result_reg.step_levels >> AXIS_COUNT) == '0) &&
                              ((result_reg.dir_levels >> AXIS_COUNT) == '0)))
        else $error("unused axis shows activity");

    // A loaded input with a stalled result must hold off new requests.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid_reg && result_valid_reg && !result_ready) |-> !tick_ready)
        else $error("request accepted while pipeline is stalled");

    // A result is produced only from a held request.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(result_valid_reg)) |-> $past(tick_valid_reg))
        else $error("result appeared without a request");

endmodule

// ----- hw/rtl/msdg_axis.sv -----
// ----------------------------------------------------------------------------
// msdg_axis
// One axis: phase accumulator, step pulse timer and direction latch.
// ----------------------------------------------------------------------------
module msdg_axis
    import msdg_pkg::*;
#(
    parameter int STEP_BIT = STEP_BIT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  axis_ctrl_t   ctrl,
    input  pulse_width_t pulse_width,
    input  vel_t         velocity,
    output axis_out_t    next_out
);

    vel_t         acc_reg,        acc_next;
    logic         last_phase_reg, last_phase_next;
    logic         last_sign_reg,  last_sign_next;
    logic         pending_reg,    pending_next;
    pulse_count_t count_reg,      count_next;
    logic         done_reg,       done_next;
    logic         step_reg,       step_next;
    logic         dir_reg,        dir_next;

    logic         phase;
    logic         hit;
    pulse_count_t count_load;
    logic         done_load;
    logic         sign;
    logic         pending_mid;

    always_comb
    begin
        phase      = acc_reg[STEP_BIT];
        hit        = (phase != last_phase_reg);
        sign       = velocity[VEL_WIDTH-1];

        last_phase_next = hit ? phase : last_phase_reg;
        count_load      = hit ? ({1'b0, pulse_width} + pulse_count_t'(1)) : count_reg;
        done_load       = hit ? 1'b0 : done_reg;

        count_next = count_load;
        done_next  = done_load;
        step_next  = step_reg;
        if (count_load != '0)
        begin
            count_next = count_load - pulse_count_t'(1);
            if (count_next != '0)
            begin
                step_next = 1'b1;
            end
            else
            begin
                step_next = 1'b0;
                done_next = 1'b1;
            end
        end

        pending_mid    = pending_reg;
        last_sign_next = last_sign_reg;
        if (!pending_reg && (sign != last_sign_reg))
        begin
            pending_mid    = 1'b1;
            last_sign_next = sign;
        end

        // Direction only moves once the pulse is over.
        pending_next = pending_mid;
        dir_next     = dir_reg;
        if (done_next && pending_mid)
        begin
            pending_next = 1'b0;
            dir_next     = last_sign_next;
        end

        acc_next = acc_reg + velocity;

        if (ctrl.clr)
        begin
            acc_next        = '0;
            last_phase_next = 1'b0;
            last_sign_next  = 1'b0;
            pending_next    = 1'b0;
            count_next      = '0;
            done_next       = 1'b1;
            step_next       = 1'b0;
            dir_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            last_phase_reg <= 1'b0;
            last_sign_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b1;
            step_reg       <= 1'b0;
            dir_reg        <= 1'b0;
        end
        else if (ctrl.en)
        begin
            acc_reg        <= acc_next;
            last_phase_reg <= last_phase_next;
            last_sign_reg  <= last_sign_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            step_reg       <= step_next;
            dir_reg        <= dir_next;
        end
    end

    assign next_out.step     = step_next;
    assign next_out.dir      = dir_next;
    assign next_out.position = acc_next;

endmodule
